### hdl/lzss_pkg.sv
// Package for the LZSS bitstream decompressor.
// Holds default sizes, the sequencer state type and the history control struct.
// No dependencies.
`default_nettype none

package lzss_pkg;

    localparam int HISTORY_SIZE_DEF = 8192;
    localparam int OFFSET_BITS_DEF  = 13;
    localparam int LENGTH_BITS_DEF  = 4;
    localparam int MIN_MATCH_DEF    = 3;
    localparam int LIT_BITS         = 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_COPY,
        ST_FLUSH
    } lzss_state_t;

    typedef struct packed {
        logic clear;
        logic wr_en;
        logic rd_en;
    } hist_ctl_t;

endpackage

`default_nettype wire

### hdl/lzss_hist.sv
// History memory of the LZSS decompressor with circular write pointer.
// Unwritten entries read as zero through fill tracking; depends on lzss_pkg.
`default_nettype none

module lzss_hist #(
    parameter int HISTORY_SIZE = lzss_pkg::HISTORY_SIZE_DEF,
    localparam int AW = $clog2(HISTORY_SIZE)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lzss_pkg::hist_ctl_t               ctl,
    input  wire logic [lzss_pkg::LIT_BITS-1:0]     wr_data,
    input  wire logic [AW-1:0]                     rd_addr,
    output logic      [lzss_pkg::LIT_BITS-1:0]     rd_data
);

    localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_SIZE - 1);

    logic [lzss_pkg::LIT_BITS-1:0] mem [HISTORY_SIZE];
    logic [lzss_pkg::LIT_BITS-1:0] rd_data_reg;
    logic                          rd_ok_reg;
    logic [AW-1:0]                 wptr_reg;
    logic                          wrapped_reg;
    logic                          full_reg;
    logic                          rd_ok;

    // Writes start at index 1 and advance by one, so written entries are 1..wptr-1
    // until the pointer wraps.
    assign rd_ok = full_reg || ((rd_addr != '0) && (wrapped_reg || (rd_addr < wptr_reg)));

    always_ff @(posedge clk) begin
        if (ctl.wr_en) begin
            mem[wptr_reg] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wptr_reg    <= AW'(1);
            wrapped_reg <= 1'b0;
            full_reg    <= 1'b0;
            rd_ok_reg   <= 1'b0;
        end else begin
            if (ctl.clear) begin
                wptr_reg    <= AW'(1);
                wrapped_reg <= 1'b0;
                full_reg    <= 1'b0;
            end else if (ctl.wr_en) begin
                wptr_reg <= wptr_reg + AW'(1);
                if (wptr_reg == LAST_IDX) begin
                    wrapped_reg <= 1'b1;
                end
                if (wptr_reg == '0) begin
                    full_reg <= 1'b1;
                end
            end
            if (ctl.rd_en) begin
                rd_ok_reg <= rd_ok;
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### hdl/lzss_bitstream_decompressor.sv
// Top level of the LZSS bitstream decompressor: bit buffer, token sequencer, output stage.
// Depends on lzss_pkg and lzss_hist.
`default_nettype none

// One compressed byte is taken per request while the block is idle; in_stall stays high
// until every byte that it causes has been handed to the output register. The token
// sequencer decodes one token at a time: a literal in its decode step, a back-reference
// in a decode step followed, per copied byte, by a registered history read and then a
// write and emit, and each padding bit after the final byte in a decode step of its own.
// An end token leads straight to the flush; otherwise a request that is not the last is
// closed by a decode step that finds no complete token, then the flush. The history is
// never swept: entries not yet written since the last first_of_stream read as zero. The
// last result of each request carries last_of_run; output stalls only hold the sequencer
// when its pending slot is full.
module lzss_bitstream_decompressor #(
    parameter int HISTORY_SIZE = lzss_pkg::HISTORY_SIZE_DEF,
    parameter int OFFSET_BITS  = lzss_pkg::OFFSET_BITS_DEF,
    parameter int LENGTH_BITS  = lzss_pkg::LENGTH_BITS_DEF,
    parameter int MIN_MATCH    = lzss_pkg::MIN_MATCH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] src_byte,
    input  wire logic       first_of_stream,
    input  wire logic       last_of_stream,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] out_byte,
    output logic            byte_valid,
    output logic            stream_done,
    output logic            last_of_run
);

    localparam int LB    = lzss_pkg::LIT_BITS;
    localparam int AW    = $clog2(HISTORY_SIZE);
    localparam int T_LIT = 1 + LB;
    localparam int T_END = 1 + OFFSET_BITS;
    localparam int T_MAT = T_END + LENGTH_BITS;
    localparam int BUF_W = T_MAT - 1 + LB;
    localparam int BH_W  = $clog2(BUF_W + 1);
    localparam int CNT_W = LENGTH_BITS + 1;

    lzss_pkg::lzss_state_t state_reg, state_next;

    logic [BUF_W-1:0] buf_reg, buf_next;
    logic [BH_W-1:0]  bits_reg, bits_next;
    logic             last_reg, last_next;
    logic             finished_reg, finished_next;
    logic [AW-1:0]    addr_reg, addr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             pend_valid_reg, pend_valid_next;
    logic [LB-1:0]    pend_byte_reg, pend_byte_next;
    logic             pend_bv_reg, pend_bv_next;
    logic             pend_done_reg, pend_done_next;

    logic             out_valid_reg, out_valid_next;
    logic [LB-1:0]    out_byte_reg, out_byte_next;
    logic             out_bv_reg, out_bv_next;
    logic             out_done_reg, out_done_next;
    logic             out_last_reg, out_last_next;

    lzss_pkg::hist_ctl_t hist_ctl;
    logic [LB-1:0]    hist_wr_data;
    logic [LB-1:0]    hist_rd_data;

    logic                   accept;
    logic                   start;
    logic [BUF_W-1:0]       aligned;
    logic                   flag;
    logic [LB-1:0]          lit;
    logic [OFFSET_BITS-1:0] off;
    logic [LENGTH_BITS-1:0] len_field;
    logic                   lit_ready;
    logic                   end_ready;
    logic                   mat_ready;
    logic                   out_free;
    logic                   can_push;

    lzss_hist #(
        .HISTORY_SIZE(HISTORY_SIZE)
    ) u_hist (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (hist_ctl),
        .wr_data(hist_wr_data),
        .rd_addr(addr_reg),
        .rd_data(hist_rd_data)
    );

    assign accept = in_valid && !in_stall;
    assign start  = accept && (first_of_stream || !finished_reg);

    // oldest held bit at the top
    assign aligned   = buf_reg << (BH_W'(BUF_W) - bits_reg);
    assign flag      = aligned[BUF_W-1];
    assign lit       = aligned[BUF_W-2 -: LB];
    assign off       = aligned[BUF_W-2 -: OFFSET_BITS];
    assign len_field = aligned[BUF_W-2-OFFSET_BITS -: LENGTH_BITS];

    assign lit_ready = (bits_reg != '0) && flag && (bits_reg >= BH_W'(T_LIT));
    assign end_ready = (bits_reg != '0) && !flag && (bits_reg >= BH_W'(T_END)) && (off == '0);
    assign mat_ready = (bits_reg != '0) && !flag && (bits_reg >= BH_W'(T_MAT)) && (off != '0);

    assign out_free = !out_valid_reg || !out_stall;
    assign can_push = !pend_valid_reg || out_free;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lzss_pkg::ST_IDLE: begin
                if (start) begin
                    state_next = lzss_pkg::ST_DECODE;
                end
            end
            lzss_pkg::ST_DECODE: begin
                if (lit_ready) begin
                    state_next = lzss_pkg::ST_DECODE;
                end else if (end_ready) begin
                    if (can_push) begin
                        state_next = lzss_pkg::ST_FLUSH;
                    end
                end else if (mat_ready) begin
                    state_next = lzss_pkg::ST_READ;
                end else if (!last_reg) begin
                    state_next = lzss_pkg::ST_FLUSH;
                end
            end
            lzss_pkg::ST_READ: begin
                state_next = lzss_pkg::ST_COPY;
            end
            lzss_pkg::ST_COPY: begin
                if (can_push) begin
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = lzss_pkg::ST_DECODE;
                    end else begin
                        state_next = lzss_pkg::ST_READ;
                    end
                end
            end
            lzss_pkg::ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = lzss_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lzss_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        logic          push;
        logic [LB-1:0] new_byte;
        logic          new_bv;
        logic          new_done;

        push     = 1'b0;
        new_byte = '0;
        new_bv   = 1'b1;
        new_done = 1'b0;

        in_stall      = (state_reg != lzss_pkg::ST_IDLE);
        hist_ctl      = '0;
        hist_wr_data  = '0;
        buf_next      = buf_reg;
        bits_next     = bits_reg;
        last_next     = last_reg;
        finished_next = finished_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;

        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        pend_bv_next    = pend_bv_reg;
        pend_done_next  = pend_done_reg;

        out_valid_next = out_valid_reg && out_stall;
        out_byte_next  = out_byte_reg;
        out_bv_next    = out_bv_reg;
        out_done_next  = out_done_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            lzss_pkg::ST_IDLE: begin
                if (accept && first_of_stream) begin
                    hist_ctl.clear = 1'b1;
                    finished_next  = 1'b0;
                end
                if (start) begin
                    if (first_of_stream) begin
                        buf_next  = BUF_W'(src_byte);
                        bits_next = BH_W'(LB);
                    end else begin
                        buf_next  = (buf_reg << LB) | BUF_W'(src_byte);
                        bits_next = bits_reg + BH_W'(LB);
                    end
                    last_next = last_of_stream;
                end
            end
            lzss_pkg::ST_DECODE: begin
                if (lit_ready) begin
                    if (can_push) begin
                        push             = 1'b1;
                        new_byte         = lit;
                        hist_ctl.wr_en   = 1'b1;
                        hist_wr_data     = lit;
                        bits_next        = bits_reg - BH_W'(T_LIT);
                        buf_next         = buf_reg & ~({BUF_W{1'b1}} << bits_next);
                    end
                end else if (end_ready) begin
                    if (can_push) begin
                        push          = 1'b1;
                        new_bv        = 1'b0;
                        new_done      = 1'b1;
                        finished_next = 1'b1;
                        buf_next      = '0;
                        bits_next     = '0;
                    end
                end else if (mat_ready) begin
                    addr_next = AW'(off);
                    cnt_next  = CNT_W'(len_field) + CNT_W'(MIN_MATCH);
                    bits_next = bits_reg - BH_W'(T_MAT);
                    buf_next  = buf_reg & ~({BUF_W{1'b1}} << bits_next);
                end else if (last_reg) begin
                    buf_next  = buf_reg << 1;
                    bits_next = bits_reg + BH_W'(1);
                end
            end
            lzss_pkg::ST_READ: begin
                hist_ctl.rd_en = 1'b1;
            end
            lzss_pkg::ST_COPY: begin
                if (can_push) begin
                    push           = 1'b1;
                    new_byte       = hist_rd_data;
                    hist_ctl.wr_en = 1'b1;
                    hist_wr_data   = hist_rd_data;
                    addr_next      = addr_reg + AW'(1);
                    cnt_next       = cnt_reg - CNT_W'(1);
                end
            end
            lzss_pkg::ST_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = pend_byte_reg;
                    out_bv_next     = pend_bv_reg;
                    out_done_next   = pend_done_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                in_stall = 1'b1;
            end
        endcase

        if (push) begin
            if (pend_valid_reg) begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_bv_next    = pend_bv_reg;
                out_done_next  = pend_done_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = new_byte;
            pend_bv_next    = new_bv;
            pend_done_next  = new_done;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= lzss_pkg::ST_IDLE;
            buf_reg        <= '0;
            bits_reg       <= '0;
            last_reg       <= 1'b0;
            finished_reg   <= 1'b0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            buf_reg        <= buf_next;
            bits_reg       <= bits_next;
            last_reg       <= last_next;
            finished_reg   <= finished_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        addr_reg      <= addr_next;
        pend_byte_reg <= pend_byte_next;
        pend_bv_reg   <= pend_bv_next;
        pend_done_reg <= pend_done_next;
        out_byte_reg  <= out_byte_next;
        out_bv_reg    <= out_bv_next;
        out_done_reg  <= out_done_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign byte_valid  = out_bv_reg;
    assign stream_done = out_done_reg;
    assign last_of_run = out_last_reg;

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= BH_W'(BUF_W))
        else $error("bit buffer overfilled");

    a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_done_reg |-> !out_bv_reg && (out_byte_reg == '0))
        else $error("done result carries data");

    a_copy_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lzss_pkg::ST_COPY |->
            $past(state_reg) == lzss_pkg::ST_READ || $past(state_reg) == lzss_pkg::ST_COPY)
        else $error("copy without history read");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lzss_pkg::ST_IDLE |-> !pend_valid_reg)
        else $error("pending result left at end of request");

    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lzss_pkg::ST_READ |-> cnt_reg != '0)
        else $error("copy count exhausted");

endmodule

`default_nettype wire

### dv/lzss_bitstream_decompressor_checker.sv
// Checker for the LZSS bitstream decompressor: watches both channels, predicts every
// decompressed result from the accepted compressed bytes and compares them in order.
// Depends on lzss_pkg for the history and token sizes.
module lzss_bitstream_decompressor_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] src_byte,
    input  logic       first_of_stream,
    input  logic       last_of_stream,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] out_byte,
    input  logic       byte_valid,
    input  logic       stream_done,
    input  logic       last_of_run,
    output int         fail_count,
    output int         pending
);

    localparam int HSIZE = lzss_pkg::HISTORY_SIZE_DEF;
    localparam int OFF_W = lzss_pkg::OFFSET_BITS_DEF;
    localparam int LEN_W = lzss_pkg::LENGTH_BITS_DEF;
    localparam int MIN_M = lzss_pkg::MIN_MATCH_DEF;
    localparam int IDX_W = $clog2(HSIZE);

    typedef struct packed {
        logic [7:0] data;
        logic       data_ok;
        logic       done;
        logic       run_end;
    } out_word_t;

    out_word_t        expected_out[$];
    logic [63:0]      bitbuf;
    int unsigned      nbits;
    logic [7:0]       hist [HSIZE];
    logic [IDX_W-1:0] wr_idx;
    bit               ended;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    function automatic int unsigned peek(int unsigned skip, int unsigned k);
        return int'((bitbuf >> (nbits - skip - k)) & ((64'd1 << k) - 64'd1));
    endfunction

    function automatic void drop(int unsigned k);
        nbits -= k;
        bitbuf &= (64'd1 << nbits) - 64'd1;
    endfunction

    function automatic void emit_result(logic [7:0] data, logic data_ok, logic done);
        expected_out.push_back('{data: data, data_ok: data_ok, done: done, run_end: 1'b0});
    endfunction

    function automatic void put_byte(logic [7:0] c);
        hist[wr_idx] = c;
        wr_idx = wr_idx + 1'b1;
        emit_result(c, 1'b1, 1'b0);
    endfunction

    function automatic void clear_stream();
        for (int i = 0; i < HSIZE; i++)
            hist[i] = 8'h00;
        bitbuf = '0;
        nbits = 0;
        wr_idx = 1;
        ended = 1'b0;
    endfunction

    // Feeds one compressed byte and queues every result it produces.
    function automatic void decode_byte(logic [7:0] b, logic first, logic last);
        int          queued_before;
        int unsigned pos;
        int unsigned run_len;
        bit          stuck;
        out_word_t   tail;
        queued_before = expected_out.size();
        if (first)
            clear_stream();
        if (ended)
            return;
        bitbuf = (bitbuf << 8) | 64'(b);
        nbits += 8;
        while (!ended)
        begin
            stuck = 1'b0;
            if (nbits == 0)
                stuck = 1'b1;
            else if (peek(0, 1) == 1)
            begin
                if (nbits >= 9)
                begin
                    put_byte(8'(peek(1, 8)));
                    drop(9);
                end
                else
                    stuck = 1'b1;
            end
            else if (nbits >= 1 + OFF_W)
            begin
                pos = peek(1, OFF_W);
                if (pos == 0)
                begin
                    ended = 1'b1;
                    bitbuf = '0;
                    nbits = 0;
                    emit_result(8'h00, 1'b0, 1'b1);
                end
                else if (nbits >= 1 + OFF_W + LEN_W)
                begin
                    run_len = peek(1 + OFF_W, LEN_W) + MIN_M;
                    drop(1 + OFF_W + LEN_W);
                    for (int unsigned i = 0; i < run_len; i++)
                        put_byte(hist[(pos + i) & (HSIZE - 1)]);
                end
                else
                    stuck = 1'b1;
            end
            else
                stuck = 1'b1;
            if (stuck)
            begin
                if (!last)
                    break;
                bitbuf = bitbuf << 1;
                nbits += 1;
            end
        end
        if (expected_out.size() > queued_before)
        begin
            tail = expected_out.pop_back();
            tail.run_end = 1'b1;
            expected_out.push_back(tail);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            clear_stream();
            expected_out.delete();
            pending <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                decode_byte(src_byte, first_of_stream, last_of_stream);
            if (out_valid && !out_stall)
            begin
                if (expected_out.size() == 0)
                begin
                    $error("unexpected result: out_byte %0h byte_valid %0b stream_done %0b",
                           out_byte, byte_valid, stream_done);
                    fail_count++;
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (out_byte !== want.data)
                    begin
                        $error("out_byte: expected %0h, got %0h", want.data, out_byte);
                        fail_count++;
                    end
                    if (byte_valid !== want.data_ok)
                    begin
                        $error("byte_valid: expected %0b, got %0b", want.data_ok, byte_valid);
                        fail_count++;
                    end
                    if (stream_done !== want.done)
                    begin
                        $error("stream_done: expected %0b, got %0b", want.done, stream_done);
                        fail_count++;
                    end
                    if (last_of_run !== want.run_end)
                    begin
                        $error("last_of_run: expected %0b, got %0b", want.run_end, last_of_run);
                        fail_count++;
                    end
                end
            end
            pending <= expected_out.size();
        end
    end

endmodule

### dv/lzss_bitstream_decompressor_tb.sv
// Testbench top for the LZSS bitstream decompressor: builds compressed streams, drives
// requests in bursts, stalls the output side and prints the verdict.
// Depends on lzss_pkg, lzss_bitstream_decompressor and its checker.
module lzss_bitstream_decompressor_tb;

    localparam int HSIZE       = lzss_pkg::HISTORY_SIZE_DEF;
    localparam int OFF_W       = lzss_pkg::OFFSET_BITS_DEF;
    localparam int LEN_W       = lzss_pkg::LENGTH_BITS_DEF;
    localparam int MIN_M       = lzss_pkg::MIN_MATCH_DEF;
    localparam int LEN_MAX     = (1 << LEN_W) - 1;
    localparam int ITEM_TARGET = 165;
    localparam int HOLD_AT     = 60;
    localparam int PAUSE_AT    = 130;
    localparam int LONG_HOLD   = 300;
    localparam int TAIL_CYCLES = 200;
    localparam int IDLE_LIMIT  = 4000;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
    typedef enum {SK_CLEAN, SK_NO_LAST, SK_PADDED, SK_NOISE, SK_TRAILING} stream_kind_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] src_byte = 8'h00;
    logic       first_of_stream = 1'b0;
    logic       last_of_stream = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       stream_done;
    logic       last_of_run;
    int         fail_count;
    int         pending;

    int         items_sent = 0;
    int         burst_left = 0;
    bit         draining = 1'b0;
    logic [7:0] stream_q[$];
    logic [7:0] pend_byte;
    int         pend_bits;
    int         out_count;

    lzss_bitstream_decompressor u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .src_byte        (src_byte),
        .first_of_stream (first_of_stream),
        .last_of_stream  (last_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .stream_done     (stream_done),
        .last_of_run     (last_of_run)
    );

    lzss_bitstream_decompressor_checker u_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .src_byte        (src_byte),
        .first_of_stream (first_of_stream),
        .last_of_stream  (last_of_stream),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_byte        (out_byte),
        .byte_valid      (byte_valid),
        .stream_done     (stream_done),
        .last_of_run     (last_of_run),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stream builder: tokens packed MSB first.
    task automatic new_stream();
        stream_q.delete();
        pend_bits = 0;
        pend_byte = 8'h00;
        out_count = 0;
    endtask

    task automatic put_bits(input logic [15:0] value, input int width);
        for (int i = width - 1; i >= 0; i--)
        begin
            pend_byte = {pend_byte[6:0], value[i]};
            pend_bits++;
            if (pend_bits == 8)
            begin
                stream_q.push_back(pend_byte);
                pend_bits = 0;
            end
        end
    endtask

    task automatic close_stream();
        if (pend_bits != 0)
            put_bits(16'h0000, 8 - pend_bits);
    endtask

    task automatic add_literal(input logic [7:0] c);
        put_bits(16'h0001, 1);
        put_bits(16'(c), 8);
        out_count++;
    endtask

    task automatic add_match(input int pos, input int len_code);
        put_bits(16'h0000, 1);
        put_bits(16'(pos), OFF_W);
        put_bits(16'(len_code), LEN_W);
        out_count += len_code + MIN_M;
    endtask

    task automatic add_end();
        put_bits(16'h0000, 1 + OFF_W);
    endtask

    task automatic add_random_token();
        int          back_dist;
        logic [OFF_W-1:0] pos;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: add_literal(8'($urandom_range(0, 255)));
            9: add_match($urandom_range(1, HSIZE - 1), $urandom_range(0, LEN_MAX));
            default:
            begin
                back_dist = $urandom_range(1, 24);
                pos = OFF_W'(1 + out_count - back_dist);
                if (pos == 0)
                    pos = 1;
                add_match(int'(pos), $urandom_range(0, LEN_MAX));
            end
        endcase
    endtask

    task automatic send_request(input logic [7:0] b, input logic f, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        src_byte <= b;
        first_of_stream <= f;
        last_of_stream <= l;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic send_stream(input bit with_first, input int last_pos);
        for (int i = 0; i < stream_q.size(); i++)
            send_request(stream_q[i], with_first && i == 0, i == last_pos);
    endtask

    task automatic build_tokens();
        int ntok;
        ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
        new_stream();
        repeat (ntok) add_random_token();
    endtask

    initial
    begin : stimulus
        stream_kind_t kind;
        int           r;
        int           cut;
        bit           paused;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // no first_of_stream: starts from reset state; overlapping copy, top position,
        // set bits after the end token, then a byte after the stream has ended
        new_stream();
        add_literal(8'h00);
        add_literal(8'hFF);
        add_literal(8'h5A);
        add_match(2, LEN_MAX);
        add_match(HSIZE - 1, 0);
        add_end();
        if (pend_bits != 0)
            put_bits(16'hFFFF, 8 - pend_bits);
        send_stream(1'b0, stream_q.size() - 1);
        send_request(8'hFF, 1'b0, 1'b1);

        // single-byte stream: partial literal completed by padding
        send_request(8'hC5, 1'b1, 1'b1);

        // final byte finishes a full match and holds a partial one
        new_stream();
        add_match(1, LEN_MAX);
        put_bits(16'h0000, 1);
        put_bits(16'h0001, 1);
        close_stream();
        send_stream(1'b1, stream_q.size() - 1);

        // end token reached without any last_of_stream
        new_stream();
        add_literal(8'($urandom_range(0, 255)));
        add_end();
        close_stream();
        send_stream(1'b1, -1);

        while (items_sent < ITEM_TARGET)
        begin
            if (!paused && items_sent >= PAUSE_AT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
                paused = 1'b1;
            end
            r = $urandom_range(0, 19);
            kind = r < 11 ? SK_CLEAN : r < 13 ? SK_NO_LAST : r < 16 ? SK_PADDED :
                   r < 18 ? SK_NOISE : SK_TRAILING;
            case (kind)
                SK_CLEAN:
                begin
                    build_tokens();
                    add_end();
                    if (pend_bits != 0 && $urandom_range(0, 1) == 1)
                        put_bits(16'($urandom_range(0, 255)), 8 - pend_bits);
                    close_stream();
                    send_stream(1'b1, stream_q.size() - 1);
                end
                SK_NO_LAST:
                begin
                    build_tokens();
                    add_end();
                    close_stream();
                    send_stream(1'b1, -1);
                end
                SK_PADDED:
                begin
                    build_tokens();
                    close_stream();
                    cut = $urandom_range(1, stream_q.size());
                    while (stream_q.size() > cut)
                        void'(stream_q.pop_back());
                    send_stream(1'b1, stream_q.size() - 1);
                end
                SK_NOISE:
                begin
                    repeat ($urandom_range(1, 6))
                        send_request(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                                     $urandom_range(0, 3) == 0);
                end
                default:
                begin
                    build_tokens();
                    add_end();
                    close_stream();
                    repeat ($urandom_range(1, 3))
                        stream_q.push_back(8'($urandom_range(0, 255)));
                    send_stream(1'b1, stream_q.size() - 1);
                end
            endcase
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        draining = 1'b1;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin : out_side
        stall_mode_t mode;
        int          span;
        bit          held;
        mode = STALL_NONE;
        span = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (draining)
                out_stall <= 1'b0;
            else if (!held && items_sent >= HOLD_AT)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(8, 60);
                end
                span--;
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    STALL_TOGGLE: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no request accepted for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

endmodule

### files.f
hdl/lzss_pkg.sv
hdl/lzss_hist.sv
hdl/lzss_bitstream_decompressor.sv
dv/lzss_bitstream_decompressor_checker.sv
dv/lzss_bitstream_decompressor_tb.sv
